// ===== src/fcsg_pkg.sv =====
// fcsg_pkg: constants, register codes and stage types for the circle span generator.
// No dependencies; filled_circle_span_generator_core uses it by scoped names.
package fcsg_pkg;

  localparam int MAX_DIM     = 4096;
  localparam int DIM_W       = 13;   // width/height/radius register width
  localparam int OFS_W       = 14;   // signed centre offsets
  localparam int LINE_W      = 12;   // scanline index
  localparam int RAD_W       = 2 * DIM_W;  // r*r and r*r - d*d
  localparam int SQRT_STEPS  = DIM_W;      // one root bit per stage
  localparam int REM_W       = DIM_W + 1;  // remainder stays <= 2*root
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_OFFSET_X      = 3'd2,
    REG_OFFSET_Y      = 3'd3,
    REG_CIRCLE_RADIUS = 3'd4
  } reg_idx_t;

  // word state inside the square root stages
  typedef struct packed {
    logic               cov;
    logic [RAD_W-1:0]   rad;
    logic [REM_W-1:0]   rem;
    logic [DIM_W-1:0]   root;
  } sqrt_stage_t;

endpackage

// ===== src/filled_circle_span_generator_core.sv =====
// filled_circle_span_generator_core: pipelined scanline span generator for a filled circle.
// Depends on fcsg_pkg (constants, register codes, sqrt stage type).
//
// Usage: configure frame size, centre offsets and radius over the APB port
// (byte addresses 0,4,8,12,16), then send scanline indexes on the in_ channel.
// Each input word yields exactly one output word: span_hit and the half-open
// span [span_left, span_right) of filled columns, both zero when span_hit is 0.
// Pipeline: 18 register stages: four setup stages (line capture, coverage and
// distance, square, radicand), thirteen integer square root stages (one root
// bit each), one clip/output stage.
// Throughput: one word per cycle while in_stall is low. Every stage has its own valid bit and loads
// when the stage after it is empty or moving, so bubbles close up and in_stall
// only rises when the whole pipe is full behind a stalled output.
// When out_stall is high the output word holds and stages fill up behind it.
// Reset (synchronous, rst_n low) empties the pipe and loads the register
// defaults: 640 x 480 frame, zero offsets, radius 5.
// Configuration may only be written while no word is in flight.
module filled_circle_span_generator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [fcsg_pkg::LINE_W-1:0]   in_scan_line,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_span_hit,
  output logic [fcsg_pkg::DIM_W-1:0]    out_span_left,
  output logic [fcsg_pkg::DIM_W-1:0]    out_span_right,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fcsg_pkg::ADDR_W-1:0]   paddr,
  input  logic [fcsg_pkg::DATA_W-1:0]   pwdata,
  output logic [fcsg_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int DW = fcsg_pkg::DIM_W;
  localparam int OW = fcsg_pkg::OFS_W;
  localparam int LW = fcsg_pkg::LINE_W;
  localparam int RW = fcsg_pkg::RAD_W;
  localparam int NS = fcsg_pkg::SQRT_STEPS;
  localparam int MW = fcsg_pkg::REM_W;

  // ---------------- configuration registers ----------------
  logic [DW-1:0] image_width_r, image_height_r, circle_radius_r;
  logic [OW-1:0] offset_x_r, offset_y_r;
  fcsg_pkg::reg_idx_t reg_sel;
  logic cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = fcsg_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= DW'(640);
      image_height_r  <= DW'(480);
      offset_x_r      <= '0;
      offset_y_r      <= '0;
      circle_radius_r <= DW'(5);
    end else if (cfg_wr) begin
      case (reg_sel)
        fcsg_pkg::REG_IMAGE_WIDTH:   image_width_r   <= pwdata[DW-1:0];
        fcsg_pkg::REG_IMAGE_HEIGHT:  image_height_r  <= pwdata[DW-1:0];
        fcsg_pkg::REG_OFFSET_X:      offset_x_r      <= pwdata[OW-1:0];
        fcsg_pkg::REG_OFFSET_Y:      offset_y_r      <= pwdata[OW-1:0];
        fcsg_pkg::REG_CIRCLE_RADIUS: circle_radius_r <= pwdata[DW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      fcsg_pkg::REG_IMAGE_WIDTH:   prdata = {{(32-DW){1'b0}}, image_width_r};
      fcsg_pkg::REG_IMAGE_HEIGHT:  prdata = {{(32-DW){1'b0}}, image_height_r};
      fcsg_pkg::REG_OFFSET_X:      prdata = {{(32-OW){1'b0}}, offset_x_r};
      fcsg_pkg::REG_OFFSET_Y:      prdata = {{(32-OW){1'b0}}, offset_y_r};
      fcsg_pkg::REG_CIRCLE_RADIUS: prdata = {{(32-DW){1'b0}}, circle_radius_r};
      default:                     prdata = '0;
    endcase
  end

  // ---------------- derived geometry, re-registered every cycle ----------------
  logic [DW-1:0]        w_sat, h_sat;
  logic [DW-1:0]        w_sat_r, h_sat_r;
  logic signed [15:0]   cx_nxt, cy_nxt, cx_r, cy_r;
  logic signed [16:0]   top_r, bot_r;
  logic [RW-1:0]        rsq_r;

  always_comb begin
    w_sat  = (image_width_r  > DW'(fcsg_pkg::MAX_DIM)) ? DW'(fcsg_pkg::MAX_DIM) : image_width_r;
    h_sat  = (image_height_r > DW'(fcsg_pkg::MAX_DIM)) ? DW'(fcsg_pkg::MAX_DIM) : image_height_r;
    cx_nxt = $signed({4'b0, w_sat[DW-1:1]}) + $signed({{2{offset_x_r[OW-1]}}, offset_x_r});
    cy_nxt = $signed({4'b0, h_sat[DW-1:1]}) + $signed({{2{offset_y_r[OW-1]}}, offset_y_r});
  end

  always_ff @(posedge clk) begin
    w_sat_r <= w_sat;
    h_sat_r <= h_sat;
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    top_r   <= {cy_nxt[15], cy_nxt} - $signed({4'b0, circle_radius_r});
    bot_r   <= {cy_nxt[15], cy_nxt} + $signed({4'b0, circle_radius_r});
    rsq_r   <= circle_radius_r * circle_radius_r;
  end

  // ---------------- ready chain ----------------
  logic rdy_o, rdy_a, rdy_b, rdy_c, rdy_d;
  logic rdy_q [NS];
  logic a_v_r, b_v_r, c_v_r, d_v_r;
  logic q_v_r [NS];
  logic out_valid_r;

  assign rdy_o    = !out_valid_r || !out_stall;
  assign rdy_d    = !d_v_r || rdy_q[0];
  assign rdy_c    = !c_v_r || rdy_d;
  assign rdy_b    = !b_v_r || rdy_c;
  assign rdy_a    = !a_v_r || rdy_b;
  assign in_stall = !rdy_a;

  // ---------------- stage A: capture line ----------------
  logic [LW-1:0] a_line_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (rdy_a) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      a_line_r <= in_scan_line;
    end
  end

  // ---------------- stage B: coverage and |cy - line| ----------------
  logic signed [16:0] line_s, d_s;
  logic               b_cov_nxt, b_cov_r;
  logic [DW:0]        b_dabs_nxt, b_dabs_r;

  always_comb begin
    line_s     = $signed({5'b0, a_line_r});
    d_s        = {cy_r[15], cy_r} - line_s;
    b_cov_nxt  = (line_s >= top_r) && (line_s < bot_r) &&
                 (line_s < $signed({4'b0, h_sat_r}));
    // beyond the radius the value is unused, truncation is harmless
    b_dabs_nxt = d_s[16] ? (DW+1)'(-d_s) : d_s[DW:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (rdy_b) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b) begin
      b_cov_r  <= b_cov_nxt;
      b_dabs_r <= b_dabs_nxt;
    end
  end

  // ---------------- stage C: d*d ----------------
  logic              c_cov_r;
  logic [2*DW+1:0]   c_dsq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (rdy_c) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c) begin
      c_cov_r <= b_cov_r;
      c_dsq_r <= b_dabs_r * b_dabs_r;
    end
  end

  // ---------------- stage D: radicand r*r - d*d ----------------
  logic [2*DW+2:0] d_diff;
  logic            d_cov_r;
  logic [RW-1:0]   d_rad_nxt, d_rad_r;

  always_comb begin
    d_diff    = {3'b0, rsq_r} - {1'b0, c_dsq_r};
    d_rad_nxt = (!c_cov_r || d_diff[2*DW+2]) ? '0 : d_diff[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (rdy_d) begin
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_d) begin
      d_cov_r <= c_cov_r;
      d_rad_r <= d_rad_nxt;
    end
  end

  // ---------------- square root, one root bit per stage ----------------
  fcsg_pkg::sqrt_stage_t q_r   [NS];
  fcsg_pkg::sqrt_stage_t q_nxt [NS];

  for (genvar j = 0; j < NS; j++) begin : g_sqrt
    localparam int B = NS - 1 - j;  // radicand digit handled here
    fcsg_pkg::sqrt_stage_t src;
    logic                  src_v;
    logic [MW+1:0]         rem_sh, trial;

    if (j == 0) begin : g_first
      assign src   = '{cov: d_cov_r, rad: d_rad_r, rem: '0, root: '0};
      assign src_v = d_v_r;
    end else begin : g_next
      assign src   = q_r[j-1];
      assign src_v = q_v_r[j-1];
    end

    if (j == NS - 1) begin : g_last_rdy
      assign rdy_q[j] = !q_v_r[j] || rdy_o;
    end else begin : g_mid_rdy
      assign rdy_q[j] = !q_v_r[j] || rdy_q[j+1];
    end

    always_comb begin
      rem_sh   = {src.rem, src.rad[2*B+1 -: 2]};
      trial    = {1'b0, src.root, 2'b01};
      q_nxt[j] = src;
      if (rem_sh >= trial) begin
        q_nxt[j].rem  = MW'(rem_sh - trial);
        q_nxt[j].root = {src.root[DW-2:0], 1'b1};
      end else begin
        q_nxt[j].rem  = rem_sh[MW-1:0];
        q_nxt[j].root = {src.root[DW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        q_v_r[j] <= 1'b0;
      end else if (rdy_q[j]) begin
        q_v_r[j] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy_q[j]) begin
        q_r[j] <= q_nxt[j];
      end
    end
  end

  // ---------------- clip and output register ----------------
  fcsg_pkg::sqrt_stage_t fin;
  logic [DW:0]        root_ceil;
  logic signed [16:0] left_s, right_s, left_c, right_c;
  logic               hit_nxt;
  logic               out_hit_r;
  logic [DW-1:0]      out_left_r, out_right_r;

  always_comb begin
    fin       = q_r[NS-1];
    // remainder nonzero means the radicand is not a perfect square
    root_ceil = {1'b0, fin.root} + (DW+1)'(fin.rem != '0);
    left_s    = {cx_r[15], cx_r} - $signed({3'b0, root_ceil});
    right_s   = {cx_r[15], cx_r} + $signed({4'b0, fin.root});
    left_c    = left_s[16] ? '0 : left_s;
    right_c   = (right_s > $signed({4'b0, w_sat_r})) ? $signed({4'b0, w_sat_r}) : right_s;
    hit_nxt   = fin.cov && (left_c < right_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_o) begin
      out_valid_r <= q_v_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o) begin
      out_hit_r   <= hit_nxt;
      out_left_r  <= hit_nxt ? left_c[DW-1:0]  : '0;
      out_right_r <= hit_nxt ? right_c[DW-1:0] : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_span_hit   = out_hit_r;
  assign out_span_left  = out_left_r;
  assign out_span_right = out_right_r;

  // ---------------- assertions ----------------
  a_hit_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_span_hit |-> out_span_left < out_span_right)
    else $error("hit word with empty span");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_span_hit |-> out_span_left == '0 && out_span_right == '0)
    else $error("miss word with nonzero span");

  a_right_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_span_right <= w_sat_r)
    else $error("span runs past frame width");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> a_v_r && b_v_r && c_v_r && d_v_r && out_valid_r && out_stall)
    else $error("input stalled with a free stage");

endmodule
